[hw/rtl/nfcfrc_pkg.sv]
// shared types and codes for the nfc reply frame receiver and checker
// used by every module of the block; depends on nothing
package nfcfrc_pkg;

	localparam int unsigned CfgIndexW = 3;

	typedef enum logic [CfgIndexW-1:0] {
		REG_PREAMBLE     = 3'd0,
		REG_START_FIRST  = 3'd1,
		REG_START_SECOND = 3'd2,
		REG_DIRECTION_ID = 3'd3,
		REG_MAX_LENGTH   = 3'd4
	} reg_index_t;

	typedef enum logic [2:0] {
		ST_OK         = 3'd0,
		ST_BAD_HEADER = 3'd1,
		ST_TOO_LONG   = 3'd2,
		ST_LEN_CSUM   = 3'd3,
		ST_WRONG_ID   = 3'd4,
		ST_DATA_CSUM  = 3'd5
	} status_t;

	typedef enum logic [2:0] {
		PH_IDLE   = 3'd0,
		PH_HEADER = 3'd1,
		PH_LEN    = 3'd2,
		PH_LCS    = 3'd3,
		PH_BODY   = 3'd4
	} phase_t;

	localparam logic [7:0] RstPreamble    = 8'h00;
	localparam logic [7:0] RstStartFirst  = 8'h00;
	localparam logic [7:0] RstStartSecond = 8'hff;
	localparam logic [7:0] RstDirectionId = 8'hd5;
	localparam logic [7:0] RstMaxLength   = 8'hff;

	typedef struct packed {
		logic [7:0] expected_preamble;
		logic [7:0] expected_start_first;
		logic [7:0] expected_start_second;
		logic [7:0] expected_direction_id;
		logic [7:0] max_length;
	} cfg_t;

	typedef struct packed {
		logic       valid;
		logic       data_valid;
		logic [7:0] data_byte;
		logic [7:0] data_index;
		logic       frame_done;
		status_t    status;
	} result_t;

endpackage

[hw/rtl/nfcfrc_cfg_regs.sv]
// configuration register file of the nfc reply frame checker
// depends on nfcfrc_pkg
module nfcfrc_cfg_regs (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [nfcfrc_pkg::CfgIndexW-1:0]   cfg_index,
	input  logic [7:0]                         cfg_data,
	output nfcfrc_pkg::cfg_t                   cfg
);

	nfcfrc_pkg::cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.expected_preamble     <= nfcfrc_pkg::RstPreamble;
			cfg_q.expected_start_first  <= nfcfrc_pkg::RstStartFirst;
			cfg_q.expected_start_second <= nfcfrc_pkg::RstStartSecond;
			cfg_q.expected_direction_id <= nfcfrc_pkg::RstDirectionId;
			cfg_q.max_length            <= nfcfrc_pkg::RstMaxLength;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				nfcfrc_pkg::REG_PREAMBLE:     cfg_q.expected_preamble     <= cfg_data;
				nfcfrc_pkg::REG_START_FIRST:  cfg_q.expected_start_first  <= cfg_data;
				nfcfrc_pkg::REG_START_SECOND: cfg_q.expected_start_second <= cfg_data;
				nfcfrc_pkg::REG_DIRECTION_ID: cfg_q.expected_direction_id <= cfg_data;
				nfcfrc_pkg::REG_MAX_LENGTH:   cfg_q.max_length            <= cfg_data;
				default: ;
			endcase
		end
	end

endmodule

[hw/rtl/nfcfrc_parser.sv]
// frame parser state machine: header, length, length checksum and body checks
// depends on nfcfrc_pkg
module nfcfrc_parser (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   step,
	input  logic [7:0]             rx_byte,
	input  logic                   frame_start,
	input  nfcfrc_pkg::cfg_t       cfg,
	output nfcfrc_pkg::result_t    res
);

	nfcfrc_pkg::phase_t phase_q, phase_d;
	logic [8:0] pos_q, pos_d;
	logic [7:0] len_q, len_d;
	logic [7:0] sum_q, sum_d;
	logic       hdr_good_q, hdr_good_d;
	logic       id_good_q, id_good_d;

	nfcfrc_pkg::phase_t phase_e;
	logic [8:0] pos_e;
	logic [7:0] sum_e;
	logic       hdr_good_e;
	logic       id_good_e;
	logic [7:0] want;
	logic [8:0] len9;
	logic [7:0] lcs_sum;
	logic [8:0] pos_m1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= nfcfrc_pkg::PH_IDLE;
			pos_q      <= '0;
			len_q      <= '0;
			sum_q      <= '0;
			hdr_good_q <= 1'b1;
			id_good_q  <= 1'b1;
		end else if (step) begin
			phase_q    <= phase_d;
			pos_q      <= pos_d;
			len_q      <= len_d;
			sum_q      <= sum_d;
			hdr_good_q <= hdr_good_d;
			id_good_q  <= id_good_d;
		end
	end

	always_comb begin
		// frame start restarts the parser on this byte
		phase_e    = frame_start ? nfcfrc_pkg::PH_HEADER : phase_q;
		pos_e      = frame_start ? 9'd0 : pos_q;
		sum_e      = frame_start ? 8'd0 : sum_q;
		hdr_good_e = frame_start ? 1'b1 : hdr_good_q;
		id_good_e  = frame_start ? 1'b1 : id_good_q;

		phase_d    = phase_e;
		pos_d      = pos_e;
		len_d      = len_q;
		sum_d      = sum_e;
		hdr_good_d = hdr_good_e;
		id_good_d  = id_good_e;

		want    = (pos_e == 9'd0) ? cfg.expected_preamble :
		          (pos_e == 9'd1) ? cfg.expected_start_first : cfg.expected_start_second;
		len9    = {1'b0, len_q};
		lcs_sum = len_q + rx_byte;
		pos_m1  = pos_e - 9'd1;

		res            = '0;
		res.status     = nfcfrc_pkg::ST_OK;

		unique case (phase_e)
			nfcfrc_pkg::PH_IDLE: ;
			nfcfrc_pkg::PH_HEADER: begin
				hdr_good_d = hdr_good_e && (rx_byte == want);
				if (pos_e >= 9'd2) begin
					pos_d = 9'd0;
					if (!hdr_good_d) begin
						res.valid      = 1'b1;
						res.frame_done = 1'b1;
						res.status     = nfcfrc_pkg::ST_BAD_HEADER;
						phase_d        = nfcfrc_pkg::PH_IDLE;
					end else begin
						phase_d = nfcfrc_pkg::PH_LEN;
					end
				end else begin
					pos_d = pos_e + 9'd1;
				end
			end
			nfcfrc_pkg::PH_LEN: begin
				len_d   = rx_byte;
				phase_d = nfcfrc_pkg::PH_LCS;
			end
			nfcfrc_pkg::PH_LCS: begin
				if (len_q > cfg.max_length) begin
					res.valid      = 1'b1;
					res.frame_done = 1'b1;
					res.status     = nfcfrc_pkg::ST_TOO_LONG;
					phase_d        = nfcfrc_pkg::PH_IDLE;
				end else if (lcs_sum != 8'd0) begin
					res.valid      = 1'b1;
					res.frame_done = 1'b1;
					res.status     = nfcfrc_pkg::ST_LEN_CSUM;
					phase_d        = nfcfrc_pkg::PH_IDLE;
				end else begin
					phase_d = nfcfrc_pkg::PH_BODY;
					pos_d   = 9'd0;
					sum_d   = 8'd0;
				end
			end
			nfcfrc_pkg::PH_BODY: begin
				if (pos_e == 9'd0)
					id_good_d = (rx_byte == cfg.expected_direction_id);
				if (pos_e <= len9)
					sum_d = sum_e + rx_byte;
				if (pos_e > len9) begin
					// postamble ends the frame
					res.valid      = 1'b1;
					res.frame_done = 1'b1;
					phase_d        = nfcfrc_pkg::PH_IDLE;
					if (!id_good_d)
						res.status = nfcfrc_pkg::ST_WRONG_ID;
					else if (sum_d != 8'd0)
						res.status = nfcfrc_pkg::ST_DATA_CSUM;
					else
						res.status = nfcfrc_pkg::ST_OK;
				end else begin
					pos_d = pos_e + 9'd1;
					if (pos_e >= 9'd1 && pos_e < len9) begin
						res.valid      = 1'b1;
						res.data_valid = 1'b1;
						res.data_byte  = rx_byte;
						res.data_index = pos_m1[7:0];
					end
				end
			end
			default: phase_d = nfcfrc_pkg::PH_IDLE;
		endcase

		if (!step)
			res.valid = 1'b0;
	end

endmodule

[hw/rtl/nfc_frame_receiver_checker.sv]
// top level of the nfc reply frame receiver and checker
// depends on nfcfrc_pkg, nfcfrc_cfg_regs and nfcfrc_parser
//
// Takes one received byte per request and accepts a new byte every cycle while not
// stalled: a byte is registered on input, parsed by combinational logic and its result,
// if any, lands in an output register. Input and parser stall only while the output
// register holds a result not yet taken. Payload bytes come out with their index; the
// end of every frame, good or bad, comes out with tlast high and a status code. Bytes
// outside a frame produce nothing. Configuration registers are written through the cfg
// port and take effect at once; write them only while no frame is in progress.
module nfc_frame_receiver_checker (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [nfcfrc_pkg::CfgIndexW-1:0] cfg_index,
	input  logic [7:0]                       cfg_data,
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	input  logic [7:0]                       s_axis_tdata,  // rx_byte
	input  logic                             s_axis_tuser,  // frame_start
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	output logic [23:0]                      m_axis_tdata,  // data_byte, data_index, status
	output logic                             m_axis_tuser,  // data_valid
	output logic                             m_axis_tlast   // frame_done
);

	nfcfrc_pkg::cfg_t    cfg;
	nfcfrc_pkg::result_t res;

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       start_s1;
	logic       advance;
	logic       step;

	logic       out_valid_q;
	logic       data_valid_q;
	logic [7:0] data_byte_q;
	logic [7:0] data_index_q;
	logic       frame_done_q;
	logic [2:0] status_q;

	nfcfrc_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	assign advance       = !out_valid_q || m_axis_tready;
	assign step          = valid_s1 && advance;
	assign s_axis_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			byte_s1  <= s_axis_tdata;
			start_s1 <= s_axis_tuser;
		end
	end

	nfcfrc_parser u_parser (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (step),
		.rx_byte     (byte_s1),
		.frame_start (start_s1),
		.cfg         (cfg),
		.res         (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= res.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res.valid) begin
			data_valid_q <= res.data_valid;
			data_byte_q  <= res.data_byte;
			data_index_q <= res.data_index;
			frame_done_q <= res.frame_done;
			status_q     <= res.status;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {5'd0, status_q, data_index_q, data_byte_q};
	assign m_axis_tuser  = data_valid_q;
	assign m_axis_tlast  = frame_done_q;

endmodule

[verif/nfcfrc_result_checker.sv]
// checker for the nfc reply frame receiver: watches the register, byte and result channels,
// predicts the parser results of every accepted byte and compares them field by field
// depends on nfcfrc_pkg
module nfcfrc_result_checker
	import nfcfrc_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	input  logic                 cfg_ready,
	input  logic [CfgIndexW-1:0] cfg_index,
	input  logic [7:0]           cfg_data,
	input  logic                 s_axis_tvalid,
	input  logic                 s_axis_tready,
	input  logic [7:0]           s_axis_tdata,  // rx_byte
	input  logic                 s_axis_tuser,  // frame_start
	input  logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	input  logic [23:0]          m_axis_tdata,  // data_byte, data_index, status
	input  logic                 m_axis_tuser,  // data_valid
	input  logic                 m_axis_tlast,  // frame_done
	output int                   outstanding,
	output int                   errors,
	output int                   frames_ended,
	output int                   payload_seen
);

	typedef struct packed {
		logic       data_valid;
		logic [7:0] data_byte;
		logic [7:0] data_index;
		logic       frame_done;
		status_t    status;
	} frame_result_t;

	cfg_t          cfg_copy;
	phase_t        parse_phase;
	logic [8:0]    pos;
	logic [7:0]    len_field;
	logic [7:0]    byte_sum;
	logic          hdr_ok;
	logic          id_ok;
	frame_result_t awaited[$];
	int            fail_count;
	int            done_count;
	int            payload_count;

	task automatic note_mismatch(input string field, input logic [7:0] want,
			input logic [7:0] got);
		$display("%0t mismatch %s: expected %02h actual %02h", $time, field, want, got);
		fail_count++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		frame_result_t r;
		logic          emit;
		logic [7:0]    b;
		logic [7:0]    want;
		logic [7:0]    lsum;
		if (!arst_n) begin
			cfg_copy.expected_preamble     = RstPreamble;
			cfg_copy.expected_start_first  = RstStartFirst;
			cfg_copy.expected_start_second = RstStartSecond;
			cfg_copy.expected_direction_id = RstDirectionId;
			cfg_copy.max_length            = RstMaxLength;
			parse_phase = PH_IDLE;
			pos         = '0;
			len_field   = '0;
			byte_sum    = '0;
			hdr_ok      = 1'b1;
			id_ok       = 1'b1;
			awaited.delete();
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (reg_index_t'(cfg_index))
					REG_PREAMBLE:     cfg_copy.expected_preamble     = cfg_data;
					REG_START_FIRST:  cfg_copy.expected_start_first  = cfg_data;
					REG_START_SECOND: cfg_copy.expected_start_second = cfg_data;
					REG_DIRECTION_ID: cfg_copy.expected_direction_id = cfg_data;
					REG_MAX_LENGTH:   cfg_copy.max_length            = cfg_data;
					default: ;
				endcase
			end

			if (s_axis_tvalid && s_axis_tready) begin
				r = '0;
				emit = 1'b0;
				b = s_axis_tdata;
				if (s_axis_tuser) begin
					parse_phase = PH_HEADER;
					pos         = '0;
					byte_sum    = '0;
					hdr_ok      = 1'b1;
					id_ok       = 1'b1;
				end
				case (parse_phase)
					PH_HEADER: begin
						want = (pos == 0) ? cfg_copy.expected_preamble :
							(pos == 1) ? cfg_copy.expected_start_first :
							cfg_copy.expected_start_second;
						if (b != want)
							hdr_ok = 1'b0;
						if (pos >= 2) begin
							pos = '0;
							if (!hdr_ok) begin
								emit = 1'b1;
								r.frame_done = 1'b1;
								r.status = ST_BAD_HEADER;
								parse_phase = PH_IDLE;
							end else begin
								parse_phase = PH_LEN;
							end
						end else begin
							pos = pos + 9'd1;
						end
					end
					PH_LEN: begin
						len_field = b;
						parse_phase = PH_LCS;
					end
					PH_LCS: begin
						lsum = len_field + b;
						if (len_field > cfg_copy.max_length) begin
							emit = 1'b1;
							r.frame_done = 1'b1;
							r.status = ST_TOO_LONG;
							parse_phase = PH_IDLE;
						end else if (lsum != 0) begin
							emit = 1'b1;
							r.frame_done = 1'b1;
							r.status = ST_LEN_CSUM;
							parse_phase = PH_IDLE;
						end else begin
							parse_phase = PH_BODY;
							pos = '0;
							byte_sum = '0;
						end
					end
					PH_BODY: begin
						if (pos == 0)
							id_ok = (b == cfg_copy.expected_direction_id);
						if (pos <= {1'b0, len_field})
							byte_sum = byte_sum + b;
						if (pos >= {1'b0, len_field} + 9'd1) begin
							emit = 1'b1;
							r.frame_done = 1'b1;
							r.status = !id_ok ? ST_WRONG_ID :
								(byte_sum != 0) ? ST_DATA_CSUM : ST_OK;
							parse_phase = PH_IDLE;
						end else begin
							if (pos >= 9'd1 && pos < {1'b0, len_field}) begin
								emit = 1'b1;
								r.data_valid = 1'b1;
								r.data_byte = b;
								r.data_index = 8'(pos - 9'd1);
							end
							pos = pos + 9'd1;
						end
					end
					default: ;
				endcase
				if (emit)
					awaited.push_back(r);
			end

			if (m_axis_tvalid && m_axis_tready) begin
				if (awaited.size() == 0) begin
					$display("%0t unexpected result: actual tdata %06h tuser %b tlast %b",
						$time, m_axis_tdata, m_axis_tuser, m_axis_tlast);
					fail_count++;
				end else begin
					r = awaited.pop_front();
					if (m_axis_tuser !== r.data_valid)
						note_mismatch("data_valid", {7'b0, r.data_valid}, {7'b0, m_axis_tuser});
					if (m_axis_tdata[7:0] !== r.data_byte)
						note_mismatch("data_byte", r.data_byte, m_axis_tdata[7:0]);
					if (m_axis_tdata[15:8] !== r.data_index)
						note_mismatch("data_index", r.data_index, m_axis_tdata[15:8]);
					if (m_axis_tlast !== r.frame_done)
						note_mismatch("frame_done", {7'b0, r.frame_done}, {7'b0, m_axis_tlast});
					if (m_axis_tdata[23:16] !== {5'b0, r.status})
						note_mismatch("status", {5'b0, r.status}, m_axis_tdata[23:16]);
					if (r.frame_done)
						done_count++;
					if (r.data_valid)
						payload_count++;
				end
			end
		end
		outstanding  <= awaited.size();
		errors       <= fail_count;
		frames_ended <= done_count;
		payload_seen <= payload_count;
	end

endmodule

[verif/nfc_frame_receiver_checker_tb.sv]
// top of the nfc reply frame receiver test: clock, reset, register writes and frame stimulus
// with random idling on both streams; results are judged by nfcfrc_result_checker
// depends on nfcfrc_pkg, nfcfrc_result_checker and nfc_frame_receiver_checker
module nfc_frame_receiver_checker_tb;
	import nfcfrc_pkg::*;

	localparam int CycleLimit   = 600000;
	localparam int SettleCycles = 4;
	localparam int NumSettings  = 6;
	localparam int ItemsPerSet  = 325;

	logic                 clk;
	logic                 arst_n        = 1'b0;
	logic                 cfg_valid     = 1'b0;
	logic                 cfg_ready;
	logic [CfgIndexW-1:0] cfg_index     = '0;
	logic [7:0]           cfg_data      = '0;
	logic                 s_axis_tvalid = 1'b0;
	logic                 s_axis_tready;
	logic [7:0]           s_axis_tdata  = '0;  // rx_byte
	logic                 s_axis_tuser  = 1'b0;  // frame_start
	logic                 m_axis_tvalid;
	logic                 m_axis_tready = 1'b0;
	logic [23:0]          m_axis_tdata;  // data_byte, data_index, status
	logic                 m_axis_tuser;  // data_valid
	logic                 m_axis_tlast;  // frame_done

	int         outstanding;
	int         errors;
	int         frames_ended;
	int         payload_seen;
	int         items_sent    = 0;
	int         send_idle_pct = 0;
	int         recv_idle_pct = 0;
	int         cycle_count   = 0;
	cfg_t       cfg_now;
	logic [7:0] frame_q[$];

	nfc_frame_receiver_checker u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	nfcfrc_result_checker u_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast),
		.outstanding   (outstanding),
		.errors        (errors),
		.frames_ended  (frames_ended),
		.payload_seen  (payload_seen)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		m_axis_tready <= arst_n && ($urandom_range(99) >= recv_idle_pct);
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CycleLimit) begin
			$display("timeout after %0d cycles, %0d results still awaited",
				cycle_count, outstanding);
			$display("CHECKS FAILED");
			$finish;
		end
	end

	task automatic send_byte(input logic [7:0] b, input logic start, input bit counted);
		if ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= b;
		s_axis_tuser  <= start;
		do @(posedge clk); while (!s_axis_tready);
		if (counted)
			items_sent++;
	endtask

	task automatic send_queued(input bit counted);
		for (int i = 0; i < frame_q.size(); i++)
			send_byte(frame_q[i], i == 0, counted);
	endtask

	// hold the sender until every predicted result is out and the pipeline is empty
	task automatic drain_results();
		s_axis_tvalid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
		repeat (SettleCycles) @(posedge clk);
	endtask

	task automatic write_config(input cfg_t c);
		for (int i = REG_PREAMBLE; i <= REG_MAX_LENGTH; i++) begin
			cfg_valid <= 1'b1;
			cfg_index <= reg_index_t'(i);
			case (reg_index_t'(i))
				REG_PREAMBLE:     cfg_data <= c.expected_preamble;
				REG_START_FIRST:  cfg_data <= c.expected_start_first;
				REG_START_SECOND: cfg_data <= c.expected_start_second;
				REG_DIRECTION_ID: cfg_data <= c.expected_direction_id;
				default:          cfg_data <= c.max_length;
			endcase
			do @(posedge clk); while (!cfg_ready);
		end
		cfg_valid <= 1'b0;
		cfg_now = c;
	endtask

	// kind picks a well-formed frame or one with a single kind of damage
	task automatic send_random_frame(input int kind);
		int         len;
		int         maxl;
		int         cut;
		logic [7:0] sum;
		logic [7:0] flip;
		logic [7:0] old_id;
		maxl = int'(cfg_now.max_length);
		len = ($urandom_range(15) == 0) ? $urandom_range(maxl) :
			$urandom_range(maxl < 10 ? maxl : 10);
		if ($urandom_range(19) == 0)
			len = maxl;
		if (kind >= 65 && kind < 70) begin
			if (maxl < 255)
				len = $urandom_range(255, maxl + 1);
			else
				kind = 70;
		end
		flip = 8'($urandom_range(255, 1));
		frame_q = '{cfg_now.expected_preamble, cfg_now.expected_start_first,
			cfg_now.expected_start_second, 8'(len), 8'(-len), cfg_now.expected_direction_id};
		sum = cfg_now.expected_direction_id;
		for (int i = 1; i < len; i++) begin
			frame_q.push_back(8'($urandom_range(255)));
			sum = sum + frame_q[frame_q.size() - 1];
		end
		if (len > 0)
			frame_q.push_back(8'(-sum));
		frame_q.push_back(8'($urandom_range(255)));

		if (kind >= 60 && kind < 65) begin
			cut = $urandom_range(2);
			frame_q[cut] = frame_q[cut] ^ flip;
		end else if (kind >= 70 && kind < 75) begin
			frame_q[4] = frame_q[4] ^ flip;
		end else if (kind >= 75 && kind < 80) begin
			old_id = frame_q[5];
			frame_q[5] = old_id ^ flip;
			// sometimes repair the sum so only the identifier is wrong
			if (len > 0 && $urandom_range(1) == 1)
				frame_q[5 + len] = frame_q[5 + len] + old_id - frame_q[5];
		end else if (kind >= 80 && kind < 85) begin
			frame_q[5 + len] = frame_q[5 + len] ^ flip;
		end else if (kind >= 85 && kind < 92) begin
			cut = $urandom_range(frame_q.size() - 1, 1);
			while (frame_q.size() > cut)
				void'(frame_q.pop_back());
		end
		// early errors: keep only the first seven bytes; those after the error must be ignored
		if (kind >= 60 && kind < 75)
			while (frame_q.size() > 7)
				void'(frame_q.pop_back());

		send_queued(1'b1);
		if (kind >= 92)
			repeat ($urandom_range(3, 1))
				send_byte(8'($urandom_range(255)), 1'b0, 1'b0);
	endtask

	initial begin
		cfg_t next_cfg;
		cfg_now.expected_preamble     = RstPreamble;
		cfg_now.expected_start_first  = RstStartFirst;
		cfg_now.expected_start_second = RstStartSecond;
		cfg_now.expected_direction_id = RstDirectionId;
		cfg_now.max_length            = RstMaxLength;
		send_idle_pct = 9;
		recv_idle_pct = 84;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// byte outside any frame after reset
		send_byte(8'h5a, 1'b0, 1'b1);
		// bad header
		frame_q = '{8'hff, 8'hff, 8'h00};
		send_queued(1'b1);
		// length checksum error
		frame_q = '{8'h00, 8'h00, 8'hff, 8'h01, 8'h00};
		send_queued(1'b1);
		// restart in mid header, then a good frame with one payload byte
		frame_q = '{8'h00, 8'h00};
		send_queued(1'b1);
		frame_q = '{8'h00, 8'h00, 8'hff, 8'h02, 8'hfe, 8'hd5, 8'hff, 8'h2c, 8'h00};
		send_queued(1'b1);
		// zero length, identifier acts as checksum
		frame_q = '{8'h00, 8'h00, 8'hff, 8'h00, 8'h00, 8'hd5, 8'hff};
		send_queued(1'b1);
		drain_results();

		for (int ph = 0; ph < NumSettings; ph++) begin
			send_idle_pct = (ph < 2) ? 9 : (ph < 4) ? 84 : 0;
			recv_idle_pct = (ph < 2) ? 84 : (ph < 4) ? 9 : 0;
			if (ph == 1) begin
				write_config('0);
			end else if (ph == 2) begin
				write_config('1);
			end else if (ph > 2) begin
				next_cfg.expected_preamble     = 8'($urandom_range(255));
				next_cfg.expected_start_first  = 8'($urandom_range(255));
				next_cfg.expected_start_second = 8'($urandom_range(255));
				next_cfg.expected_direction_id = 8'($urandom_range(255));
				next_cfg.max_length = ($urandom_range(3) == 0) ? 8'($urandom_range(255)) :
					8'($urandom_range(40));
				write_config(next_cfg);
			end
			while (items_sent < (ph + 1) * ItemsPerSet) begin
				send_random_frame($urandom_range(99));
				if ($urandom_range(49) == 0)
					drain_results();
			end
			send_random_frame(0);
			drain_results();
		end

		$display("covered %0d counted bytes under %0d register settings", items_sent,
			NumSettings);
		$display("compared %0d frame ends and %0d payload bytes", frames_ended, payload_seen);
		if (errors == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
